@@ rtl/avd_pkg.sv @@
// shared types, constants and helpers for the vertex dedup block
`timescale 1ns / 1ps
`default_nettype none
package avd_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int LANE_W      = 20;
  localparam int BASIS_W     = 16;
  localparam int CROSS_W     = 33;
  localparam int PROD_W      = CROSS_W + LANE_W;
  localparam int ACC_W       = 56;
  localparam int CFG_W       = 60;

  localparam logic [1:0] REG_BASIS_E1 = 2'd0;
  localparam logic [1:0] REG_BASIS_E2 = 2'd1;
  localparam logic [1:0] REG_ORIGIN   = 2'd2;

  typedef struct packed {
    logic signed [LANE_W-1:0] z;
    logic signed [LANE_W-1:0] y;
    logic signed [LANE_W-1:0] x;
  } point_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {F_IDLE, F_CALC, F_PUSH} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_SRCH} back_state_t;
  typedef enum logic [2:0] {M_LOAD, M_CSUB, M_INIT, M_ADD, M_FIN} mac_op_t;

  function automatic logic signed [LANE_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-29:0] r;
    r = v[ACC_W-1:28];
    if (r > (ACC_W-28)'(524287))       round_sat = LANE_W'(524287);
    else if (r < -(ACC_W-28)'(524288)) round_sat = -LANE_W'(524288);
    else                               round_sat = r[LANE_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/avd_front.sv @@
// front end: takes a point and runs the affine transform on one shared multiplier
`timescale 1ns / 1ps
`default_nettype none
module avd_front import avd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic signed [LANE_W-1:0] in_x,
  input  wire logic signed [LANE_W-1:0] in_y,
  input  wire logic signed [LANE_W-1:0] in_z,
  input  wire logic [47:0]              basis_e1,
  input  wire logic [47:0]              basis_e2,
  input  wire logic [59:0]              origin_offset,
  input  wire q_stat_t                  q_stat,
  output logic                          q_wr,
  output point_t                        q_wdata
);

  front_state_t state, state_next;
  logic [3:0] step;
  point_t p;
  logic signed [CROSS_W-1:0] c [3];
  logic signed [ACC_W-1:0] acc;
  point_t res;

  logic signed [BASIS_W-1:0] a0, a1, a2, b0, b1, b2;
  logic signed [LANE_W-1:0]  o0, o1, o2;
  logic signed [CROSS_W-1:0] op_a;
  logic signed [LANE_W-1:0]  op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   term14, sum;
  mac_op_t mop;
  logic [1:0] idx;
  logic signed [LANE_W-1:0] o_sel;

  assign a0 = basis_e1[15:0];
  assign a1 = basis_e1[31:16];
  assign a2 = basis_e1[47:32];
  assign b0 = basis_e2[15:0];
  assign b1 = basis_e2[31:16];
  assign b2 = basis_e2[47:32];
  assign o0 = origin_offset[19:0];
  assign o1 = origin_offset[39:20];
  assign o2 = origin_offset[59:40];

  // step schedule: six steps for the cross product, then three per output lane
  always_comb begin
    op_a  = CROSS_W'(a0);
    op_b  = LANE_W'(b0);
    mop   = M_LOAD;
    idx   = 2'd0;
    o_sel = o0;
    unique case (step)
      4'd0:  begin op_a = CROSS_W'(a1); op_b = LANE_W'(b2); mop = M_LOAD; end
      4'd1:  begin op_a = CROSS_W'(a2); op_b = LANE_W'(b1); mop = M_CSUB; idx = 2'd0; end
      4'd2:  begin op_a = CROSS_W'(a2); op_b = LANE_W'(b0); mop = M_LOAD; end
      4'd3:  begin op_a = CROSS_W'(a0); op_b = LANE_W'(b2); mop = M_CSUB; idx = 2'd1; end
      4'd4:  begin op_a = CROSS_W'(a0); op_b = LANE_W'(b1); mop = M_LOAD; end
      4'd5:  begin op_a = CROSS_W'(a1); op_b = LANE_W'(b0); mop = M_CSUB; idx = 2'd2; end
      4'd6:  begin op_a = CROSS_W'(a0); op_b = p.x; mop = M_INIT; o_sel = o0; end
      4'd7:  begin op_a = CROSS_W'(b0); op_b = p.y; mop = M_ADD; end
      4'd8:  begin op_a = c[0]; op_b = p.z; mop = M_FIN; idx = 2'd0; end
      4'd9:  begin op_a = CROSS_W'(a1); op_b = p.x; mop = M_INIT; o_sel = o1; end
      4'd10: begin op_a = CROSS_W'(b1); op_b = p.y; mop = M_ADD; end
      4'd11: begin op_a = c[1]; op_b = p.z; mop = M_FIN; idx = 2'd1; end
      4'd12: begin op_a = CROSS_W'(a2); op_b = p.x; mop = M_INIT; o_sel = o2; end
      4'd13: begin op_a = CROSS_W'(b2); op_b = p.y; mop = M_ADD; end
      4'd14: begin op_a = c[2]; op_b = p.z; mop = M_FIN; idx = 2'd2; end
      default: begin end
    endcase
  end

  assign prod   = PROD_W'(op_a) * PROD_W'(op_b);
  assign term14 = ACC_W'(prod) <<< 14;
  assign sum    = acc + ACC_W'(prod);

  always_comb begin
    state_next = state;
    full       = (state != F_IDLE);
    q_wr       = 1'b0;
    q_wdata    = res;
    unique case (state)
      F_IDLE: if (push) state_next = F_CALC;
      F_CALC: if (step == 4'd14) state_next = F_PUSH;
      F_PUSH: begin
        q_wr = !q_stat.full;
        if (!q_stat.full) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= 4'd0;
    end else begin
      state <= state_next;
      if (state == F_CALC) step <= step + 4'd1;
      else                 step <= 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      p.x <= in_x;
      p.y <= in_y;
      p.z <= in_z;
    end
    if (state == F_CALC) begin
      case (mop)
        M_LOAD: acc <= ACC_W'(prod);
        M_CSUB: c[idx] <= CROSS_W'(acc - ACC_W'(prod));
        M_INIT: acc <= term14 + (ACC_W'(o_sel) <<< 28) + (ACC_W'(1) <<< 27);
        M_ADD:  acc <= acc + term14;
        M_FIN: begin
          case (idx)
            2'd0:    res.x <= round_sat(sum);
            2'd1:    res.y <= round_sat(sum);
            default: res.z <= round_sat(sum);
          endcase
        end
        default: begin end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/avd_queue.sv @@
// two-word queue between the transform front end and the table search
`timescale 1ns / 1ps
`default_nettype none
module avd_queue import avd_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   wr,
  input  wire point_t wdata,
  input  wire logic   rd,
  output point_t      rdata,
  output q_stat_t     stat
);

  point_t slot [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign stat.full  = (cnt == 2'd2);
  assign stat.empty = (cnt == 2'd0);
  assign rdata      = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= !wp;
      if (rd) rp <= !rp;
      cnt <= cnt + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) slot[wp] <= wdata;
  end

endmodule
`default_nettype wire

@@ rtl/avd_back.sv @@
// back end: linear search of the point table, append and result register
`timescale 1ns / 1ps
`default_nettype none
module avd_back import avd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire q_stat_t  q_stat,
  input  wire point_t   q_rdata,
  output logic          q_rd,
  output logic          empty,
  input  wire logic     pop,
  output logic [10:0]   vertex_index,
  output logic          was_new,
  output logic          table_full,
  output point_t        out_pt
);

  logic [59:0] mem [TABLE_DEPTH];
  logic [59:0] rdata;
  back_state_t state, state_next;
  point_t key;
  logic [CNT_W-1:0] count, rd_ptr, cmp_idx;
  logic cmp_valid;
  logic out_valid;
  logic res_free, found, done, issue, append;

  assign res_free = !out_valid || pop;
  assign found    = cmp_valid && (rdata == key);
  assign empty    = !out_valid;

  always_comb begin
    state_next = state;
    q_rd   = 1'b0;
    done   = 1'b0;
    issue  = 1'b0;
    append = 1'b0;
    unique case (state)
      B_IDLE: if (!q_stat.empty) begin
        q_rd       = 1'b1;
        state_next = B_SRCH;
      end
      B_SRCH: begin
        if (found || rd_ptr == count) begin
          // decide only when the result register can take the word
          if (res_free) begin
            done       = 1'b1;
            append     = !found && (count < CNT_W'(TABLE_DEPTH));
            state_next = B_IDLE;
          end
        end else begin
          issue = 1'b1;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      cmp_valid <= 1'b0;
      rd_ptr    <= '0;
    end else begin
      state <= state_next;
      if (q_rd) begin
        rd_ptr    <= '0;
        cmp_valid <= 1'b0;
      end else if (issue) begin
        rd_ptr    <= rd_ptr + CNT_W'(1);
        cmp_valid <= 1'b1;
      end
      if (append) count <= count + CNT_W'(1);
      if (done)     out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) key <= q_rdata;
    if (issue) cmp_idx <= rd_ptr;
    if (done) begin
      out_pt     <= key;
      was_new    <= append;
      table_full <= !found && !append;
      if (found)       vertex_index <= 11'(cmp_idx + CNT_W'(1));
      else if (append) vertex_index <= 11'(count + CNT_W'(1));
      else             vertex_index <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (append) mem[count[ADDR_W-1:0]] <= key;
  end

  always_ff @(posedge clk) begin
    if (issue) rdata <= mem[rd_ptr[ADDR_W-1:0]];
  end

endmodule
`default_nettype wire

@@ rtl/affine_vertex_dedup_top.sv @@
// a word passes through the transform, then the two-word queue, then the linear search of the table
// the front end takes no new point until its last one is in the queue; the search takes one word at a time
// the transform of the next word overlaps the search of the current one
// reset: synchronous, clears the table count, queue and result register and loads
// the basis and origin registers with their defaults; the table itself is not cleared
`timescale 1ns / 1ps
`default_nettype none
module affine_vertex_dedup_top import avd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic signed [LANE_W-1:0] in_x,
  input  wire logic signed [LANE_W-1:0] in_y,
  input  wire logic signed [LANE_W-1:0] in_z,
  output logic                          empty,
  input  wire logic                     pop,
  output logic [10:0]                   vertex_index,
  output logic                          was_new,
  output logic                          table_full,
  output logic signed [LANE_W-1:0]      out_x,
  output logic signed [LANE_W-1:0]      out_y,
  output logic signed [LANE_W-1:0]      out_z,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data
);

  logic [47:0] basis_e1, basis_e2;
  logic [59:0] origin_offset;
  q_stat_t q_stat;
  logic q_wr, q_rd;
  point_t q_wdata, q_rdata, out_pt;

  always_ff @(posedge clk) begin
    if (rst) begin
      basis_e1      <= 48'd16384;
      basis_e2      <= 48'd1073741824;
      origin_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASIS_E1: basis_e1      <= cfg_data[47:0];
        REG_BASIS_E2: basis_e2      <= cfg_data[47:0];
        REG_ORIGIN:   origin_offset <= cfg_data[59:0];
        default: begin end
      endcase
    end
  end

  avd_front u_front (
    .clk, .rst, .push, .full, .in_x, .in_y, .in_z,
    .basis_e1, .basis_e2, .origin_offset,
    .q_stat, .q_wr, .q_wdata
  );

  avd_queue u_queue (
    .clk, .rst, .wr(q_wr), .wdata(q_wdata), .rd(q_rd), .rdata(q_rdata), .stat(q_stat)
  );

  avd_back u_back (
    .clk, .rst, .q_stat, .q_rdata, .q_rd, .empty, .pop,
    .vertex_index, .was_new, .table_full, .out_pt
  );

  assign out_x = out_pt.x;
  assign out_y = out_pt.y;
  assign out_z = out_pt.z;

  a_new_has_index: assert property (@(posedge clk) disable iff (rst)
    !empty && was_new |-> vertex_index != 11'd0)
    else $error("new word without index");

  a_full_drops: assert property (@(posedge clk) disable iff (rst)
    !empty && table_full |-> vertex_index == 11'd0 && !was_new)
    else $error("dropped word carries an index");

  a_queue_flow: assert property (@(posedge clk) disable iff (rst)
    !(q_wr && q_stat.full) && !(q_rd && q_stat.empty))
    else $error("queue overrun or underrun");

endmodule
`default_nettype wire

@@ dv/vertex_dedup_checker.sv @@
// checker for the vertex dedup block: predicts each word and compares the results
`timescale 1ns / 1ps
module vertex_dedup_checker import avd_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     push,
  input  wire logic                     full,
  input  wire logic signed [LANE_W-1:0] in_x,
  input  wire logic signed [LANE_W-1:0] in_y,
  input  wire logic signed [LANE_W-1:0] in_z,
  input  wire logic                     empty,
  input  wire logic                     pop,
  input  wire logic [10:0]              vertex_index,
  input  wire logic                     was_new,
  input  wire logic                     table_full,
  input  wire logic signed [LANE_W-1:0] out_x,
  input  wire logic signed [LANE_W-1:0] out_y,
  input  wire logic signed [LANE_W-1:0] out_z,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_index,
  input  wire logic [CFG_W-1:0]         cfg_data,
  output int                            errors,
  output int                            pending,
  output int                            stored
);

  typedef struct {
    logic [10:0]              index;
    logic                     is_new;
    logic                     dropped;
    logic signed [LANE_W-1:0] x;
    logic signed [LANE_W-1:0] y;
    logic signed [LANE_W-1:0] z;
  } vertex_result_t;

  vertex_result_t       expected_vertices[$];
  logic [47:0]          e1, e2;
  logic [CFG_W-1:0]     origin;
  logic [3*LANE_W-1:0]  unique_points[TABLE_DEPTH];
  int                   point_count;
  int                   mismatches;

  function automatic longint basis_lane(logic [47:0] v, int k);
    logic signed [15:0] t;
    t = v[16*k +: 16];
    return t;
  endfunction

  function automatic longint coord_lane(logic [3*LANE_W-1:0] v, int k);
    logic signed [LANE_W-1:0] t;
    t = v[LANE_W*k +: LANE_W];
    return t;
  endfunction

  // 28 fraction bits down to an integer, ties up, then clamp to the lane range
  function automatic logic [LANE_W-1:0] round_lane(longint acc);
    longint r;
    r = (acc + (longint'(1) <<< 27)) >>> 28;
    if (r > 524287) r = 524287;
    if (r < -524288) r = -524288;
    return r[LANE_W-1:0];
  endfunction

  function automatic vertex_result_t transform_and_lookup(logic [3*LANE_W-1:0] pt);
    longint a[3], b[3], c[3], o[3], p[3], acc;
    logic [LANE_W-1:0] l[3];
    logic [3*LANE_W-1:0] key;
    vertex_result_t r;
    for (int k = 0; k < 3; k++) begin
      a[k] = basis_lane(e1, k);
      b[k] = basis_lane(e2, k);
      o[k] = coord_lane(origin, k);
      p[k] = coord_lane(pt, k);
    end
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    for (int k = 0; k < 3; k++) begin
      acc = (a[k] * p[0] + b[k] * p[1]) * 16384 + c[k] * p[2] + (o[k] <<< 28);
      l[k] = round_lane(acc);
    end
    key = {l[2], l[1], l[0]};
    r.index = '0;
    r.is_new = 1'b0;
    r.dropped = 1'b0;
    r.x = l[0];
    r.y = l[1];
    r.z = l[2];
    for (int i = 0; i < point_count; i++) begin
      if (unique_points[i] == key) begin
        r.index = 11'(i + 1);
        break;
      end
    end
    if (r.index == 0) begin
      if (point_count < TABLE_DEPTH) begin
        unique_points[point_count] = key;
        point_count++;
        r.index = 11'(point_count);
        r.is_new = 1'b1;
      end else begin
        r.dropped = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    vertex_result_t want;
    if (rst) begin
      e1 = 48'd16384;
      e2 = 48'd1 << 30;
      origin = '0;
      point_count = 0;
      mismatches = 0;
      expected_vertices.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BASIS_E1: begin
            e1 = cfg_data[47:0];
          end
          REG_BASIS_E2: begin
            e2 = cfg_data[47:0];
          end
          REG_ORIGIN: begin
            origin = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (pop && !empty) begin
        if (expected_vertices.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, got index %0d", $time, vertex_index);
        end else begin
          want = expected_vertices.pop_front();
          check_field("vertex_index", want.index, vertex_index);
          check_field("was_new", want.is_new, was_new);
          check_field("table_full", want.dropped, table_full);
          check_field("out_x", want.x, out_x);
          check_field("out_y", want.y, out_y);
          check_field("out_z", want.z, out_z);
        end
      end
      if (push && !full)
        expected_vertices = {expected_vertices, transform_and_lookup({in_z, in_y, in_x})};
    end
    errors <= mismatches;
    pending <= expected_vertices.size();
    stored <= point_count;
  end

endmodule

@@ dv/testbench.sv @@
// stimulus and verdict for the vertex dedup block
`timescale 1ns / 1ps
module testbench;
  import avd_pkg::*;

  logic                     clk;
  logic                     rst;
  logic                     push;
  logic                     full;
  logic signed [LANE_W-1:0] in_x, in_y, in_z;
  logic                     empty;
  logic                     pop;
  logic [10:0]              vertex_index;
  logic                     was_new;
  logic                     table_full;
  logic signed [LANE_W-1:0] out_x, out_y, out_z;
  logic                     cfg_we;
  logic [1:0]               cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  int                       errors, pending, stored;

  logic [3*LANE_W-1:0] sent_points[$];
  bit                  hold_off;
  bit                  no_idle;
  int                  rx_wait;

  affine_vertex_dedup_top dut (.*);

  vertex_dedup_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 60) return 0;
    if (r < 93) return $urandom_range(4, 1);
    return $urandom_range(60, 12);
  endfunction

  // receiver: random pop, with one long hold-off on request
  initial begin
    pop = 1'b0;
    rx_wait = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        pop <= 1'b0;
        repeat (4000) @(negedge clk);
        hold_off = 1'b0;
      end else if (rx_wait > 0) begin
        pop <= 1'b0;
        rx_wait--;
      end else begin
        pop <= 1'b1;
        rx_wait = pick_gap();
      end
    end
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic offer_point(input logic [3*LANE_W-1:0] pt);
    push <= 1'b1;
    {in_z, in_y, in_x} <= pt;
    sent_points = {sent_points, pt};
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      push <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_transform(input logic [63:0] a, input logic [63:0] b,
                               input logic [63:0] o);
    drain();
    write_reg(REG_BASIS_E1, a[CFG_W-1:0]);
    write_reg(REG_BASIS_E2, b[CFG_W-1:0]);
    write_reg(REG_ORIGIN, o[CFG_W-1:0]);
  endtask

  function automatic logic [3*LANE_W-1:0] pack_point(int x, int y, int z);
    return {LANE_W'(z), LANE_W'(y), LANE_W'(x)};
  endfunction

  function automatic logic [3*LANE_W-1:0] pick_point();
    int r;
    r = $urandom_range(9);
    if (r < 4 && sent_points.size() > 0)
      return sent_points[$urandom_range(sent_points.size() - 1)];
    if (r < 6)
      return pack_point($urandom_range(31) - 16, $urandom_range(31) - 16,
                        $urandom_range(31) - 16);
    return (3*LANE_W)'({$urandom, $urandom});
  endfunction

  task automatic run_random(input int n, input bit with_hold);
    for (int i = 0; i < n; i++) begin
      no_idle = (i % 50) >= 40;
      if (with_hold && i == n / 3) hold_off = 1'b1;
      offer_point(pick_point());
      idle_sender(pick_gap());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    in_x = '0;
    in_y = '0;
    in_z = '0;
    cfg_we = 1'b0;
    cfg_index = REG_BASIS_E1;
    cfg_data = '0;
    hold_off = 1'b0;
    no_idle = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset transform is the identity: extremes, repeats and checkerboards
    offer_point(pack_point(0, 0, 0));
    offer_point(pack_point(524287, 524287, 524287));
    offer_point(pack_point(-524288, -524288, -524288));
    offer_point(pack_point(0, 0, 0));
    offer_point(pack_point(524287, -524288, -1));
    offer_point({20'h55555, 20'haaaaa, 20'h55555});
    offer_point({20'haaaaa, 20'h55555, 20'haaaaa});
    offer_point(pack_point(524287, 524287, 524287));

    // largest basis lanes and origin at the top: sums saturate high or low
    set_transform(64'h7fff_7fff_7fff, 64'h7fff_7fff_7fff, 64'h7ffff_7ffff_7ffff);
    offer_point(pack_point(524287, 524287, 524287));
    offer_point(pack_point(-524288, -524288, -524288));
    offer_point(pack_point(524287, -524288, 524287));
    // most negative lanes in the first basis, origin at the bottom
    set_transform(64'h8000_8000_8000, 64'h7fff_8000_7fff, 64'h80000_80000_80000);
    offer_point(pack_point(524287, 524287, 524287));
    offer_point(pack_point(-524288, -524288, -524288));
    offer_point(pack_point(-1, 1, -1));
    // zero basis: every point lands on the origin, so all match
    set_transform(64'hffff_0000_0000_0000, 64'hf000_0000_0000_0000, 64'h12345_fedcb_00001);
    offer_point(pack_point(1, 2, 3));
    offer_point(pack_point(-524288, 524287, 0));
    offer_point(pack_point(77, -77, 7));

    set_transform({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    run_random(145, 1'b0);
    set_transform(64'h0000_0000_4000, 64'h0000_4000_0000,
                  {8'($urandom_range(255)), 8'($urandom_range(255)), 16'h0, $urandom});
    run_random(145, 1'b1);
    set_transform({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
    run_random(145, 1'b0);
    set_transform({16'h0, 16'($urandom_range(65535)), $urandom},
                  {$urandom, $urandom}, 64'h0);
    run_random(145, 1'b0);

    // fill the table with distinct points under the identity
    set_transform(64'h4000, 64'h4000_0000, 64'h0);
    no_idle = 1'b1;
    for (int k = 0; stored < TABLE_DEPTH; k++) begin
      offer_point(pack_point(k * 7 + 3, -k, 100));
      if (k % 64 == 0) idle_sender($urandom_range(8));
    end
    no_idle = 1'b0;

    // table full: fresh points are dropped, stored ones still match
    for (int i = 0; i < 40; i++) begin
      if (i % 2 == 0) begin
        int k;
        k = $urandom_range(300);
        offer_point(pack_point(k * 7 + 3, -k, 100));
      end else begin
        offer_point((3*LANE_W)'({$urandom, $urandom}));
      end
      idle_sender(pick_gap());
    end

    drain();
    repeat (40) @(negedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
